/* rtl/three_axis_moving_average_assert.svh */
// Assertion macros for the three-axis moving average block.
`ifndef THREE_AXIS_MOVING_AVERAGE_ASSERT_SVH
`define THREE_AXIS_MOVING_AVERAGE_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled during reset
`define TAM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset
`define TAM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define TAM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TAM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/tam_pkg.sv */
// Shared types and constants for the three-axis moving average block.
package tam_pkg;

  localparam int DATA_W     = 16;
  localparam int WINDOW_DEF = 15;

  typedef logic signed [DATA_W-1:0] sample_t;

  // Input beat: one sample per axis
  typedef struct packed {
    sample_t accel_x;
    sample_t accel_y;
    sample_t accel_z;
  } accel_t;

  // Output beat: one window mean per axis
  typedef struct packed {
    sample_t mean_x;
    sample_t mean_y;
    sample_t mean_z;
  } mean_t;

endpackage

/* rtl/tam_ring.sv */
// Sample ring memory: one read and one write port, valid bits, write-to-read forwarding.
module tam_ring #(
  parameter int DEPTH  = tam_pkg::WINDOW_DEF,
  parameter int ADDR_W = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               rd_en,
  input  logic [ADDR_W-1:0]  rd_addr,
  input  logic               wr_en,
  input  logic [ADDR_W-1:0]  wr_addr,
  input  tam_pkg::accel_t    wr_data,
  output tam_pkg::accel_t    rd_data
);
  import tam_pkg::*;

  accel_t              mem [DEPTH];
  logic [DEPTH-1:0]    vld_r;
  accel_t              raw_r;
  accel_t              fwd_r;
  logic                fwd_sel_r;
  logic                ok_r;

  // Storage write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Storage read, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      raw_r <= mem[rd_addr];
      fwd_r <= wr_data;
    end
  end

  // Entry valid bits: an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      ok_r      <= 1'b0;
      fwd_sel_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        ok_r      <= vld_r[rd_addr];
        fwd_sel_r <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  // Read data: forwarded write, stored entry, or reset value
  always_comb begin
    if (fwd_sel_r) begin
      rd_data = fwd_r;
    end else if (ok_r) begin
      rd_data = raw_r;
    end else begin
      rd_data = '0;
    end
  end

endmodule

/* rtl/tam_div.sv */
// Two-stage divide of a signed running total by the window length, truncated toward zero.
module tam_div #(
  parameter int WINDOW = tam_pkg::WINDOW_DEF,
  parameter int SUM_W  = 20
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [SUM_W-1:0] sum,
  output tam_pkg::sample_t        mean
);
  import tam_pkg::*;

  // Reciprocal floor(2^SUM_W / WINDOW); quotient estimate is exact or one low
  localparam logic [SUM_W:0] RECIP = (SUM_W+1)'((64'd1 << SUM_W) / WINDOW);
  localparam logic [SUM_W-1:0] WIN = SUM_W'(WINDOW);

  logic [SUM_W-1:0]   mag;
  logic [2*SUM_W:0]   prod;
  logic [SUM_W-1:0]   q0_r;
  logic [SUM_W-1:0]   mag_r;
  logic               neg_r;
  logic [SUM_W-1:0]   rem;
  logic [SUM_W-1:0]   q_fix;
  logic [SUM_W-1:0]   q_sgn;
  sample_t            mean_r;

  // Stage A: magnitude times reciprocal
  always_comb begin
    mag  = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    prod = (2*SUM_W+1)'(mag) * (2*SUM_W+1)'(RECIP);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q0_r  <= prod[2*SUM_W-1:SUM_W];
      mag_r <= mag;
      neg_r <= sum[SUM_W-1];
    end
  end

  // Stage B: remainder correction, then restore the sign
  always_comb begin
    rem   = mag_r - SUM_W'(q0_r * WIN);
    q_fix = (rem >= WIN) ? q0_r + SUM_W'(1) : q0_r;
    q_sgn = neg_r ? SUM_W'(-q_fix) : q_fix;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mean_r <= q_sgn[DATA_W-1:0];
    end
  end

  assign mean = mean_r;

endmodule

/* rtl/three_axis_moving_average.sv */
// Top level of the three-axis moving average filter.
// Per-axis moving average over the last WINDOW samples, with a running total in a
// ring memory. Takes one beat per clock while the output is not stalled, and passes
// each result through the read of the ring, the total update, then two divide stages,
// the second of which is the output register. The sustained rate of one beat per
// cycle is set by the single-port-pair ring memory: each cycle reads the next slot
// while the previous beat writes its slot, with forwarding when both hit the same
// entry. A stall on the output holds the whole pipeline and shows up as in_stall.
// The rings start at zero, so the first WINDOW-1 results average in zeros. Means
// truncate toward zero.
`include "three_axis_moving_average_assert.svh"

module three_axis_moving_average #(
  parameter int WINDOW = tam_pkg::WINDOW_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  tam_pkg::accel_t  in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output tam_pkg::mean_t   out_data
);
  import tam_pkg::*;

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W  = DATA_W + $clog2(WINDOW);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

  logic                     adv;
  logic                     in_acc;
  logic [SLOT_W-1:0]        slot_r;
  logic [SLOT_W-1:0]        slot_nxt;

  logic                     s1_vld_r;
  accel_t                   s1_smp_r;
  logic [SLOT_W-1:0]        s1_slot_r;
  accel_t                   old_smp;
  logic                     wr_en;

  logic signed [SUM_W-1:0]  sum_x_r, sum_y_r, sum_z_r;
  logic signed [SUM_W-1:0]  sum_x_nxt, sum_y_nxt, sum_z_nxt;
  logic signed [SUM_W-1:0]  s2_x_r, s2_y_r, s2_z_r;
  logic                     s2_vld_r;
  logic                     s3_vld_r;
  logic                     out_valid_r;

  // Pipeline moves when the output register is free or being taken
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;
  assign in_acc   = in_valid && adv;

  // Ring slot pointer
  assign slot_nxt = (slot_r == SLOT_LAST) ? '0 : slot_r + SLOT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else if (in_acc) begin
      slot_r <= slot_nxt;
    end
  end

  // Stage 1 payload: sample and its slot, while the ring reads the old sample
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_smp_r  <= in_data;
      s1_slot_r <= slot_r;
    end
  end

  assign wr_en = adv && s1_vld_r;

  tam_ring #(
    .DEPTH  (WINDOW),
    .ADDR_W (SLOT_W)
  ) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (adv),
    .rd_addr (slot_r),
    .wr_en   (wr_en),
    .wr_addr (s1_slot_r),
    .wr_data (s1_smp_r),
    .rd_data (old_smp)
  );

  // Running totals: drop the oldest sample, add the new one
  always_comb begin
    sum_x_nxt = sum_x_r - SUM_W'(old_smp.accel_x) + SUM_W'(s1_smp_r.accel_x);
    sum_y_nxt = sum_y_r - SUM_W'(old_smp.accel_y) + SUM_W'(s1_smp_r.accel_y);
    sum_z_nxt = sum_z_r - SUM_W'(old_smp.accel_z) + SUM_W'(s1_smp_r.accel_z);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r <= '0;
      sum_y_r <= '0;
      sum_z_r <= '0;
    end else if (wr_en) begin
      sum_x_r <= sum_x_nxt;
      sum_y_r <= sum_y_nxt;
      sum_z_r <= sum_z_nxt;
    end
  end

  // Stage 2 payload: totals handed to the dividers
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_x_r <= sum_x_nxt;
      s2_y_r <= sum_y_nxt;
      s2_z_r <= sum_z_nxt;
    end
  end

  // Beat valid through the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r    <= in_acc;
      s2_vld_r    <= s1_vld_r;
      s3_vld_r    <= s2_vld_r;
      out_valid_r <= s3_vld_r;
    end
  end

  // Divide by window length, one unit per axis
  tam_div #(.WINDOW(WINDOW), .SUM_W(SUM_W)) u_div_x (
    .clk (clk), .en (adv), .sum (s2_x_r), .mean (out_data.mean_x)
  );
  tam_div #(.WINDOW(WINDOW), .SUM_W(SUM_W)) u_div_y (
    .clk (clk), .en (adv), .sum (s2_y_r), .mean (out_data.mean_y)
  );
  tam_div #(.WINDOW(WINDOW), .SUM_W(SUM_W)) u_div_z (
    .clk (clk), .en (adv), .sum (s2_z_r), .mean (out_data.mean_z)
  );

  assign out_valid = out_valid_r;

  // Checks
  `TAM_ASSERT_IMP(a_slot_range, clk, rst_n, 1'b1, slot_r <= SLOT_LAST)
  `TAM_ASSERT_NXT(a_slot_step, clk, rst_n, in_acc && (slot_r != SLOT_LAST), slot_r == $past(slot_r) + SLOT_W'(1))
  `TAM_ASSERT_NXT(a_out_follows, clk, rst_n, adv && s3_vld_r, out_valid_r)
  `TAM_ASSERT_NXT(a_hold_pipe, clk, rst_n, !adv, $stable(s1_vld_r) && $stable(slot_r) && $stable(sum_x_r))

endmodule

/* sim/three_axis_moving_average_tb.sv */
// Self-checking testbench for the three-axis moving average filter.
module three_axis_moving_average_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tam_pkg::*;

  localparam int WINDOW      = WINDOW_DEF;
  localparam int RAND_ITEMS  = 700;
  localparam int LATENCY     = 4;
  localparam int QUIET_LIMIT = 2000;

  // Kinds of random segment
  typedef enum int {MIX_UNIFORM, MIX_HOLD, MIX_TINY, MIX_RAIL} mix_t;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_stall;
  accel_t  in_data = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  mean_t   out_data;

  accel_t  accel_q[$];
  mean_t   mean_q[$];
  logic    in_beat = 1'b0;
  int      sent_cnt = 0;
  int      total_items = 1;
  int      quiet = 0;
  int      errors = 0;

  // Predictor state: per-axis window history, running totals, write slot
  int      hist[3][WINDOW];
  int      total[3];
  int      slot;

  three_axis_moving_average #(.WINDOW(WINDOW)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Advance the window by one beat and return the three means
  function automatic mean_t next_mean(accel_t a);
    int    s[3];
    int    avg[3];
    mean_t m;
    s[0] = a.accel_x;
    s[1] = a.accel_y;
    s[2] = a.accel_z;
    for (int ax = 0; ax < 3; ax++) begin
      total[ax] -= hist[ax][slot];
      hist[ax][slot] = s[ax];
      total[ax] += s[ax];
      avg[ax] = total[ax] / WINDOW;  // truncates toward zero
    end
    slot = (slot + 1 >= WINDOW) ? 0 : slot + 1;
    m.mean_x = sample_t'(avg[0]);
    m.mean_y = sample_t'(avg[1]);
    m.mean_z = sample_t'(avg[2]);
    return m;
  endfunction

  function automatic void push_item(int x, int y, int z);
    accel_t a;
    a.accel_x = sample_t'(x);
    a.accel_y = sample_t'(y);
    a.accel_z = sample_t'(z);
    accel_q.push_back(a);
  endfunction

  // Pick one sample for the given segment kind
  function automatic int draw(mix_t mix, int hold);
    case (mix)
      MIX_HOLD: return hold;
      MIX_TINY: return int'($urandom_range(0, 6)) - 3;
      MIX_RAIL: begin
        if ($urandom_range(0, 1)) return 32767 - int'($urandom_range(0, 255));
        return -32768 + int'($urandom_range(0, 255));
      end
      default:  return int'(sample_t'($urandom));
    endcase
  endfunction

  function automatic int pick_hold();
    case ($urandom_range(0, 2))
      0:       return 32767;
      1:       return -32768;
      default: return int'(sample_t'($urandom));
    endcase
  endfunction

  // Idle percentages by phase: receiver-heavy, sender-heavy, then none
  function automatic int send_gap();
    int ph;
    ph = (sent_cnt * 3) / total_items;
    return (ph == 0) ? 31 : (ph == 1) ? 45 : 0;
  endfunction

  function automatic int recv_gap();
    int ph;
    ph = (sent_cnt * 3) / total_items;
    return (ph == 0) ? 45 : (ph == 1) ? 31 : 0;
  endfunction

  // Driver: new beat when idle or last beat taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      in_data   <= '0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || in_beat) begin
        if (accel_q.size() != 0 && $urandom_range(0, 99) >= send_gap()) begin
          in_valid <= 1'b1;
          in_data  <= accel_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_gap());
    end
  end

  // Monitor: predict on input beats, check output beats, watchdog
  always @(posedge clk) begin
    mean_t want;
    if (rst_n) begin
      in_beat <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        mean_q.push_back(next_mean(in_data));
        sent_cnt++;
      end
      if (out_valid && !out_stall) begin
        if (mean_q.size() == 0) begin
          $display("%0t: unexpected result, got %0d %0d %0d", $time,
                   out_data.mean_x, out_data.mean_y, out_data.mean_z);
          errors++;
        end else begin
          want = mean_q.pop_front();
          if (out_data.mean_x !== want.mean_x) begin
            $display("%0t: mean_x expected %0d, got %0d", $time, want.mean_x,
                     out_data.mean_x);
            errors++;
          end
          if (out_data.mean_y !== want.mean_y) begin
            $display("%0t: mean_y expected %0d, got %0d", $time, want.mean_y,
                     out_data.mean_y);
            errors++;
          end
          if (out_data.mean_z !== want.mean_z) begin
            $display("%0t: mean_z expected %0d, got %0d", $time, want.mean_z,
                     out_data.mean_z);
            errors++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, quiet);
        $display("three_axis_moving_average regression: fail");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int   cnt;
    int   len;
    mix_t mix;
    int   hx, hy, hz;

    foreach (hist[ax, k]) hist[ax][k] = 0;
    foreach (total[ax]) total[ax] = 0;
    slot = 0;

    // Warm-up from zero, then a full window with x and y at the rails
    push_item(0, 0, 0);
    for (int k = 0; k < WINDOW; k++) push_item(32767, -32768, 1);
    // Small negative and positive samples against rail values: truncation toward zero
    for (int k = 0; k < 5; k++) push_item(-1, 1, -32768);
    for (int k = 0; k < 4; k++) push_item(-32768, 32767, -1);

    // Random segments: uniform most often, also long steady runs, tiny values, near-rail
    cnt = 0;
    while (cnt < RAND_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: mix = MIX_UNIFORM;
        4, 5:       mix = MIX_HOLD;
        6, 7:       mix = MIX_TINY;
        default:    mix = MIX_RAIL;
      endcase
      len = (mix == MIX_HOLD) ? $urandom_range(WINDOW, WINDOW + 8) : $urandom_range(1, 24);
      hx = pick_hold();
      hy = pick_hold();
      hz = pick_hold();
      for (int k = 0; k < len; k++) push_item(draw(mix, hx), draw(mix, hy), draw(mix, hz));
      cnt += len;
    end
    total_items = accel_q.size();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Drain, then keep running to catch stray results
    while (accel_q.size() != 0 || in_valid || mean_q.size() != 0) @(negedge clk);
    repeat (LATENCY * 4) @(negedge clk);

    if (errors == 0) begin
      $display("three_axis_moving_average regression: pass");
    end else begin
      $display("three_axis_moving_average regression: fail");
    end
    $finish;
  end

endmodule

/* three_axis_moving_average.f */
+incdir+rtl
rtl/tam_pkg.sv
rtl/tam_ring.sv
rtl/tam_div.sv
rtl/three_axis_moving_average.sv
sim/three_axis_moving_average_tb.sv
